[hdl/wrme_pkg.sv]
// ----------------------------------------------------------------------------
// wrme_pkg
// Shared widths, register indexes and state types of the RMS envelope block.
// ----------------------------------------------------------------------------
package wrme_pkg;

   localparam int SAMPLE_WIDTH = 16;
   localparam int LEVEL_WIDTH  = 16;
   localparam int LENGTH_WIDTH = 13;
   localparam int ALPHA_WIDTH  = 17;
   localparam int SUM_WIDTH    = 43;
   localparam int AVG_WIDTH    = 32;

   // |sample|^2 is at most 2^30
   localparam int SQUARE_WIDTH = 31;
   // mean square is at most 2^30
   localparam int QUOT_WIDTH   = 31;
   localparam int RADIX_WIDTH  = QUOT_WIDTH + 1;
   localparam int SQREM_WIDTH  = LEVEL_WIDTH + 2;
   localparam int STEP_WIDTH   = 5;

   localparam int DIV_STEPS    = QUOT_WIDTH;
   localparam int ROOT_STEPS   = RADIX_WIDTH / 2;
   localparam int MUL_STEPS    = ALPHA_WIDTH;

   localparam int MAX_WINDOW   = 4096;
   localparam int ALPHA_ONE    = 65536;

   localparam int CSR_DATA_WIDTH = 17;

   typedef enum logic [0:0] {
      CSR_WINDOW_LENGTH = 1'b0,
      CSR_EMA_ALPHA     = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_WAIT_ROOT,
      ST_PREP,
      ST_SCALE,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      RT_IDLE,
      RT_DIVIDE,
      RT_ROOT
   } root_state_type;

endpackage

[hdl/windowed_rms_envelope_ema.sv]
// ----------------------------------------------------------------------------
// windowed_rms_envelope_ema
// Block RMS level of signed audio words with one-pole exponential smoothing.
//
// Each sample word is squared and summed into the open window. For a closing
// sample (window full, or last set) the mean comes from a bit-serial divide,
// the root from a two-bit-per-cycle square root and the smoothing step from
// a serial alpha multiply. The result word sits in an output register, so a
// new sample is taken while it waits. Window length 0 acts as 1 and lengths
// above 4096 act as 4096; alpha above 65536 acts as 65536 (no smoothing).
// The config port is always ready; the user must see that it is written
// only while the block is idle, which the block itself does not enforce.
// A last sample clears the sum, count and average.
// ----------------------------------------------------------------------------
module windowed_rms_envelope_ema
   import wrme_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   input  logic                          req_last,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [LEVEL_WIDTH-1:0]        rsp_raw_level,
   output logic [LEVEL_WIDTH-1:0]        rsp_smoothed_level,

   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  csr_index_type                 csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]     csr_data
);

   state_type                  state_ff, state_in;
   logic [LENGTH_WIDTH-1:0]    len_ff, len_in;
   logic [ALPHA_WIDTH-1:0]     alpha_ff, alpha_in;
   logic [SQUARE_WIDTH-1:0]    prod_ff, prod_in;
   logic                       last_ff, last_in;
   logic [SUM_WIDTH-1:0]       sum_ff, sum_in;
   logic [LENGTH_WIDTH-1:0]    fill_ff, fill_in;
   logic [AVG_WIDTH-1:0]       avg_ff, avg_in;
   logic [AVG_WIDTH-1:0]       dist_ff, dist_in;
   logic                       toward_ff, toward_in;
   logic [AVG_WIDTH-1:0]       hi_ff, hi_in;
   logic [ALPHA_WIDTH-1:0]     mult_ff, mult_in;
   logic [STEP_WIDTH-1:0]      step_ff, step_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_WIDTH-1:0]     rsp_raw_ff, rsp_raw_in;
   logic [LEVEL_WIDTH-1:0]     rsp_smooth_ff, rsp_smooth_in;

   logic                       req_take;
   logic [SAMPLE_WIDTH-1:0]    mag;
   logic [2*SAMPLE_WIDTH-1:0]  square_full;
   logic [SUM_WIDTH-1:0]       sum_new;
   logic [LENGTH_WIDTH-1:0]    fill_inc;
   logic [LENGTH_WIDTH-1:0]    fill_new;
   logic [LENGTH_WIDTH-1:0]    len_eff;
   logic                       close;
   logic [ALPHA_WIDTH-1:0]     alpha_sat;
   logic [AVG_WIDTH-1:0]       target;
   logic [AVG_WIDTH-1:0]       addend;
   logic [AVG_WIDTH:0]         mul_sum;
   logic [AVG_WIDTH-1:0]       y_new;
   logic                       out_free;
   logic                       root_start;
   logic                       root_done;
   logic [LEVEL_WIDTH-1:0]     root;

   wrme_mean_root u_mean_root (
      .clock (clock),
      .reset (reset),
      .start (root_start),
      .sum   (sum_new),
      .count (fill_new),
      .done  (root_done),
      .root  (root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= LENGTH_WIDTH'(800);
         alpha_ff     <= ALPHA_WIDTH'(ALPHA_ONE);
         sum_ff       <= '0;
         fill_ff      <= '0;
         avg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         alpha_ff     <= alpha_in;
         sum_ff       <= sum_in;
         fill_ff      <= fill_in;
         avg_ff       <= avg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      prod_ff       <= prod_in;
      last_ff       <= last_in;
      dist_ff       <= dist_in;
      toward_ff     <= toward_in;
      hi_ff         <= hi_in;
      mult_ff       <= mult_in;
      step_ff       <= step_in;
      rsp_raw_ff    <= rsp_raw_in;
      rsp_smooth_ff <= rsp_smooth_in;
   end

   always_comb begin
      req_take    = req_valid && (state_ff == ST_IDLE);
      mag         = req_sample[SAMPLE_WIDTH-1] ? (~req_sample + 1'b1) : req_sample;
      square_full = (2*SAMPLE_WIDTH)'(mag) * (2*SAMPLE_WIDTH)'(mag);

      sum_new  = sum_ff + SUM_WIDTH'(prod_ff);
      fill_inc = fill_ff + 1'b1;
      fill_new = (fill_inc == '0) ? LENGTH_WIDTH'(1) : fill_inc;

      if (len_ff == '0) begin
         len_eff = LENGTH_WIDTH'(1);
      end else if (len_ff > LENGTH_WIDTH'(MAX_WINDOW)) begin
         len_eff = LENGTH_WIDTH'(MAX_WINDOW);
      end else begin
         len_eff = len_ff;
      end
      close = last_ff || (fill_new >= len_eff);

      alpha_sat = (alpha_ff > ALPHA_WIDTH'(ALPHA_ONE)) ? ALPHA_WIDTH'(ALPHA_ONE) : alpha_ff;
      target    = {root, {(AVG_WIDTH-LEVEL_WIDTH){1'b0}}};
      addend    = mult_ff[0] ? dist_ff : '0;
      mul_sum   = {1'b0, hi_ff} + {1'b0, addend};
      y_new     = toward_ff ? (avg_ff + hi_ff) : (avg_ff - hi_ff);
      out_free  = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      state_in      = state_ff;
      len_in        = len_ff;
      alpha_in      = alpha_ff;
      prod_in       = prod_ff;
      last_in       = last_ff;
      sum_in        = sum_ff;
      fill_in       = fill_ff;
      avg_in        = avg_ff;
      dist_in       = dist_ff;
      toward_in     = toward_ff;
      hi_in         = hi_ff;
      mult_in       = mult_ff;
      step_in       = step_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_raw_in    = rsp_raw_ff;
      rsp_smooth_in = rsp_smooth_ff;
      root_start    = 1'b0;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_WINDOW_LENGTH: len_in   = csr_data[LENGTH_WIDTH-1:0];
            CSR_EMA_ALPHA:     alpha_in = csr_data[ALPHA_WIDTH-1:0];
            default:           len_in   = len_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               prod_in  = square_full[SQUARE_WIDTH-1:0];
               last_in  = req_last;
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            if (close) begin
               root_start = 1'b1;
               sum_in     = '0;
               fill_in    = '0;
               state_in   = ST_WAIT_ROOT;
            end else begin
               sum_in   = sum_new;
               fill_in  = fill_new;
               state_in = ST_IDLE;
            end
         end
         ST_WAIT_ROOT: begin
            if (root_done) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            toward_in = target >= avg_ff;
            dist_in   = (target >= avg_ff) ? (target - avg_ff) : (avg_ff - target);
            hi_in     = '0;
            mult_in   = alpha_sat;
            step_in   = STEP_WIDTH'(MUL_STEPS - 1);
            state_in  = ST_SCALE;
         end
         ST_SCALE: begin
            // LSB-first shift-add; the top alpha bit is added unshifted
            mult_in = mult_ff >> 1;
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               hi_in    = mul_sum[AVG_WIDTH-1:0];
               state_in = ST_FINISH;
            end else begin
               hi_in = mul_sum[AVG_WIDTH:1];
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_raw_in    = root;
               rsp_smooth_in = y_new[AVG_WIDTH-1 -: LEVEL_WIDTH];
               avg_in        = last_ff ? '0 : y_new;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_raw_level      = rsp_raw_ff;
   assign rsp_smoothed_level = rsp_smooth_ff;
   assign csr_ready          = 1'b1;

endmodule

[hdl/wrme_mean_root.sv]
// ----------------------------------------------------------------------------
// wrme_mean_root
// Serial mean and square root: restoring divide one quotient bit per cycle,
// then digit-by-digit root two radicand bits per cycle.
// ----------------------------------------------------------------------------
module wrme_mean_root
   import wrme_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [SUM_WIDTH-1:0]    sum,
   input  logic [LENGTH_WIDTH-1:0] count,
   output logic                    done,
   output logic [LEVEL_WIDTH-1:0]  root
);

   root_state_type            state_ff, state_in;
   logic [STEP_WIDTH-1:0]     step_ff, step_in;
   logic [LENGTH_WIDTH-1:0]   divisor_ff, divisor_in;
   logic [LENGTH_WIDTH-1:0]   rem_ff, rem_in;
   logic [RADIX_WIDTH-1:0]    shift_ff, shift_in;
   logic [SQREM_WIDTH-1:0]    sq_rem_ff, sq_rem_in;
   logic [LEVEL_WIDTH-1:0]    root_ff, root_in;
   logic                      done_ff, done_in;

   logic [LENGTH_WIDTH:0]     div_trial;
   logic [LENGTH_WIDTH:0]     div_diff;
   logic                      div_ge;
   logic [SQREM_WIDTH+1:0]    sq_acc;
   logic [SQREM_WIDTH+1:0]    sq_trial;
   logic [SQREM_WIDTH+1:0]    sq_diff;
   logic                      sq_ge;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= RT_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      step_ff    <= step_in;
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
      shift_ff   <= shift_in;
      sq_rem_ff  <= sq_rem_in;
      root_ff    <= root_in;
   end

   always_comb begin
      div_trial = {rem_ff, shift_ff[RADIX_WIDTH-1]};
      div_diff  = div_trial - {1'b0, divisor_ff};
      div_ge    = div_trial >= {1'b0, divisor_ff};

      sq_acc    = {sq_rem_ff, shift_ff[RADIX_WIDTH-1 -: 2]};
      sq_trial  = {2'b00, root_ff, 2'b01};
      sq_diff   = sq_acc - sq_trial;
      sq_ge     = sq_acc >= sq_trial;
   end

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      shift_in   = shift_ff;
      sq_rem_in  = sq_rem_ff;
      root_in    = root_ff;
      done_in    = 1'b0;

      unique case (state_ff)
         RT_IDLE: begin
            if (start) begin
               // top bits of the sum are always below the count
               rem_in     = {1'b0, sum[SUM_WIDTH-1:QUOT_WIDTH]};
               shift_in   = {sum[QUOT_WIDTH-1:0], 1'b0};
               divisor_in = count;
               step_in    = STEP_WIDTH'(DIV_STEPS - 1);
               state_in   = RT_DIVIDE;
            end
         end
         RT_DIVIDE: begin
            rem_in   = div_ge ? div_diff[LENGTH_WIDTH-1:0] : div_trial[LENGTH_WIDTH-1:0];
            shift_in = {shift_ff[RADIX_WIDTH-2:0], div_ge};
            step_in  = step_ff - 1'b1;
            if (step_ff == '0) begin
               sq_rem_in = '0;
               root_in   = '0;
               step_in   = STEP_WIDTH'(ROOT_STEPS - 1);
               state_in  = RT_ROOT;
            end
         end
         RT_ROOT: begin
            sq_rem_in = sq_ge ? sq_diff[SQREM_WIDTH-1:0] : sq_acc[SQREM_WIDTH-1:0];
            root_in   = {root_ff[LEVEL_WIDTH-2:0], sq_ge};
            shift_in  = {shift_ff[RADIX_WIDTH-3:0], 2'b00};
            step_in   = step_ff - 1'b1;
            if (step_ff == '0) begin
               done_in  = 1'b1;
               state_in = RT_IDLE;
            end
         end
         default: begin
            state_in = RT_IDLE;
         end
      endcase
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
